### design/nptm_pkg.sv
// Shared types and constants for the NAPT port mapping table.
// Holds the request/result words, the table entry layout and the
// controller/datapath command and status structs. No dependencies.
package nptm_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int IP_W   = 32;
	localparam int PORT_W = 16;

	// Request kinds
	localparam logic [1:0] KIND_OUTBOUND = 2'd0;
	localparam logic [1:0] KIND_INT_LKUP = 2'd1;
	localparam logic [1:0] KIND_EXT_LKUP = 2'd2;
	localparam logic [1:0] KIND_UNUSED   = 2'd3;

	// Configuration register indexes
	localparam logic CFG_MIN_PORT = 1'b0;
	localparam logic CFG_MAX_PORT = 1'b1;

	// Register reset values
	localparam logic [PORT_W-1:0] MIN_PORT_RST = 16'd1024;
	localparam logic [PORT_W-1:0] MAX_PORT_RST = 16'd65535;

	typedef struct packed {
		logic [1:0]        kind;
		logic              proto;
		logic [IP_W-1:0]   inside_ip;
		logic [PORT_W-1:0] inside_port;
		logic [PORT_W-1:0] outside_port;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              created;
		logic              table_full;
		logic [IP_W-1:0]   mapped_ip;
		logic [PORT_W-1:0] mapped_inside_port;
		logic [PORT_W-1:0] mapped_outside_port;
	} res_t;

	typedef struct packed {
		logic              proto;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] inside_port;
		logic [PORT_W-1:0] outside_port;
	} ent_t;

	// Controller -> datapath
	typedef struct packed {
		logic start;     // latch request, arm the scan
		logic scan;      // issue reads newest first
		logic take_hit;  // capture the matching entry as result
		logic miss;      // insert / flag full / zero result
		logic push;      // move result into the output register
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic match;     // compared entry matches the request
		logic drained;   // nothing left to read or compare
		logic out_busy;  // output word held and stalled
	} sts_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_MISS,
		S_DONE
	} state_t;

endpackage

### design/nptm_ctl.sv
// Controller state machine for the NAPT port mapping table.
// Sequences accept, scan, miss handling and result hand-off.
// Depends on nptm_pkg.
module nptm_ctl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  nptm_pkg::sts_t  st,
	output nptm_pkg::cmd_t  cmd
);

	nptm_pkg::state_t state_q;
	nptm_pkg::state_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nptm_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			nptm_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_nx  = nptm_pkg::S_SCAN;
				end
			end
			nptm_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.match) begin
					cmd.take_hit = 1'b1;
					state_nx     = nptm_pkg::S_DONE;
				end else if (st.drained) begin
					state_nx = nptm_pkg::S_MISS;
				end
			end
			nptm_pkg::S_MISS: begin
				cmd.miss = 1'b1;
				state_nx = nptm_pkg::S_DONE;
			end
			nptm_pkg::S_DONE: begin
				if (!st.out_busy) begin
					cmd.push = 1'b1;
					state_nx = nptm_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = nptm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### design/nptm_dp.sv
// Datapath for the NAPT port mapping table: entry memory, scan
// pointer, compare, port counters, config registers and output word.
// Depends on nptm_pkg; driven by commands from nptm_ctl.
module nptm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nptm_pkg::req_t                    in_word,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [nptm_pkg::PORT_W-1:0]       cfg_data,
	input  nptm_pkg::cmd_t                    cmd,
	output nptm_pkg::sts_t                    st,
	output logic                              out_valid,
	input  logic                              out_stall,
	output nptm_pkg::res_t                    out_word
);

	// Entry memory
	nptm_pkg::ent_t mem [nptm_pkg::TABLE_DEPTH];

	logic [nptm_pkg::PORT_W-1:0] min_q, max_q, icmp_q, tcp_q;
	logic [nptm_pkg::CNT_W-1:0]  cnt_q;
	nptm_pkg::req_t              req_q;
	logic [nptm_pkg::IDX_W-1:0]  scan_q;
	logic                        more_q;
	logic                        rd_vld_s1;
	nptm_pkg::ent_t              rd_s1;
	nptm_pkg::res_t              res_q;
	logic                        out_vld_q;
	nptm_pkg::res_t              out_q;

	logic                        rd_en;
	logic                        eq_in, eq_out, eq;
	logic [nptm_pkg::PORT_W-1:0] port_cur, port_adv;
	logic [nptm_pkg::PORT_W:0]   port_inc;
	logic                        room, is_out, ins;
	nptm_pkg::ent_t              wr_ent;
	logic [nptm_pkg::CNT_W-1:0]  cnt_dec;

	// Compare the entry read last cycle
	assign rd_en  = cmd.scan && more_q;
	assign eq_in  = (rd_s1.proto == req_q.proto) && (rd_s1.ip == req_q.inside_ip)
		&& (rd_s1.inside_port == req_q.inside_port);
	assign eq_out = (rd_s1.proto == req_q.proto)
		&& (rd_s1.outside_port == req_q.outside_port);
	assign eq     = (req_q.kind == nptm_pkg::KIND_EXT_LKUP) ? eq_out : eq_in;

	assign st.match    = rd_vld_s1 && eq;
	assign st.drained  = !rd_vld_s1 && !more_q;
	assign st.out_busy = out_vld_q && out_stall;

	// Port allocation for an insert
	assign port_cur = req_q.proto ? tcp_q : icmp_q;
	assign port_inc = {1'b0, port_cur} + {{nptm_pkg::PORT_W{1'b0}}, 1'b1};
	assign port_adv = (port_inc >= {1'b0, max_q}) ? min_q
		: port_inc[nptm_pkg::PORT_W-1:0];

	assign room    = (cnt_q != nptm_pkg::CNT_W'(nptm_pkg::TABLE_DEPTH));
	assign is_out  = (req_q.kind == nptm_pkg::KIND_OUTBOUND);
	assign ins     = cmd.miss && is_out && room;
	assign cnt_dec = cnt_q - {{(nptm_pkg::CNT_W-1){1'b0}}, 1'b1};

	always_comb begin
		wr_ent.proto        = req_q.proto;
		wr_ent.ip           = req_q.inside_ip;
		wr_ent.inside_port  = req_q.inside_port;
		wr_ent.outside_port = port_cur;
	end

	// Memory write on insert, registered read during scan
	always_ff @(posedge clk) begin
		if (ins) begin
			mem[cnt_q[nptm_pkg::IDX_W-1:0]] <= wr_ent;
		end
		if (rd_en) begin
			rd_s1 <= mem[scan_q];
		end
	end

	// Config registers, port counters and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= nptm_pkg::MIN_PORT_RST;
			max_q  <= nptm_pkg::MAX_PORT_RST;
			icmp_q <= nptm_pkg::MIN_PORT_RST;
			tcp_q  <= nptm_pkg::MIN_PORT_RST;
			cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == nptm_pkg::CFG_MIN_PORT) begin
					min_q  <= cfg_data;
					icmp_q <= cfg_data;
					tcp_q  <= cfg_data;
				end else begin
					max_q <= cfg_data;
				end
			end
			if (ins) begin
				cnt_q <= cnt_q + {{(nptm_pkg::CNT_W-1){1'b0}}, 1'b1};
				if (req_q.proto) begin
					tcp_q <= port_adv;
				end else begin
					icmp_q <= port_adv;
				end
			end
		end
	end

	// Scan pointer, newest entry first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			more_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (cmd.start) begin
				more_q <= (cnt_q != '0) && (in_word.kind != nptm_pkg::KIND_UNUSED);
			end else if (rd_en) begin
				if (scan_q == '0) begin
					more_q <= 1'b0;
				end
			end
		end
	end

	// Request latch and scan address
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q  <= in_word;
			scan_q <= cnt_dec[nptm_pkg::IDX_W-1:0];
		end else if (rd_en) begin
			scan_q <= scan_q - {{(nptm_pkg::IDX_W-1){1'b0}}, 1'b1};
		end
	end

	// Result staging
	always_ff @(posedge clk) begin
		if (cmd.take_hit) begin
			res_q.hit                 <= 1'b1;
			res_q.created             <= 1'b0;
			res_q.table_full          <= 1'b0;
			res_q.mapped_ip           <= rd_s1.ip;
			res_q.mapped_inside_port  <= rd_s1.inside_port;
			res_q.mapped_outside_port <= rd_s1.outside_port;
		end else if (cmd.miss) begin
			if (ins) begin
				res_q.hit                 <= 1'b0;
				res_q.created             <= 1'b1;
				res_q.table_full          <= 1'b0;
				res_q.mapped_ip           <= req_q.inside_ip;
				res_q.mapped_inside_port  <= req_q.inside_port;
				res_q.mapped_outside_port <= port_cur;
			end else begin
				res_q.hit                 <= 1'b0;
				res_q.created             <= 1'b0;
				res_q.table_full          <= is_out;
				res_q.mapped_ip           <= '0;
				res_q.mapped_inside_port  <= '0;
				res_q.mapped_outside_port <= '0;
			end
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.push) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_vld_q;
	assign out_word  = out_q;

endmodule

### design/nat_port_mapping_table.sv
// NAPT port mapping table, top level. Entries are scanned newest first,
// one per cycle out of a single-port memory with registered read.
// A hit ends the scan at the matching entry; a miss reads every entry, then an
// outbound request inserts or flags the table full; an empty table or the unused
// kind reads no entry. A stalled output word holds back the result. The next word
// is accepted in the cycle after the result is loaded; words are taken one at a time.
// Reset empties the table and loads the port registers.
module nat_port_mapping_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  nptm_pkg::req_t               in_word,
	output logic                         out_valid,
	input  logic                         out_stall,
	output nptm_pkg::res_t               out_word,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [nptm_pkg::PORT_W-1:0]  cfg_data
);

	nptm_pkg::cmd_t cmd;
	nptm_pkg::sts_t st;

	nptm_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	nptm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	// Never overwrite a held, stalled output word
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !st.out_busy)
		else $error("result pushed over a stalled output word");

	// Controller phases never overlap
	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.scan, cmd.miss, cmd.push}))
		else $error("overlapping controller commands");

	// An accepted word blocks further input until its result is pushed
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a word is in progress");

	// Miss handling lasts exactly one cycle
	a_miss_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.miss |=> !cmd.miss)
		else $error("miss handling repeated");

endmodule

### tb/nat_port_mapping_table_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for nat_port_mapping_table: directed words, then random phases
// under several port ranges, checked against a translation predictor kept here.
// Depends on nptm_pkg for the request/result words, kinds and register indexes.
module nat_port_mapping_table_tb;
	import nptm_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int PHASE_WORDS = 240;

	typedef struct packed {
		logic              proto;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
	} host_key_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	req_t              in_word = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	res_t              out_word;
	logic              cfg_we = 1'b0;
	logic              cfg_index = CFG_MIN_PORT;
	logic [PORT_W-1:0] cfg_data = '0;

	// predictor state: translation table, port counters, port range
	ent_t              map_tbl [TABLE_DEPTH];
	int                map_count = 0;
	logic [PORT_W-1:0] next_port [2] = '{MIN_PORT_RST, MIN_PORT_RST};
	logic [PORT_W-1:0] lo_port = MIN_PORT_RST;
	logic [PORT_W-1:0] wrap_port = MAX_PORT_RST;

	req_t      requests_pending [$];
	res_t      translations_due [$];
	host_key_t hosts [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit squeeze_armed = 1'b0;
	int squeeze_left = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	nat_port_mapping_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Translate one request word, updating the table and counters on an insert
	function automatic res_t napt_translate(input req_t rq);
		res_t            r;
		int              idx;
		logic [PORT_W:0] bumped;
		r = '0;
		idx = -1;
		case (rq.kind)
		KIND_OUTBOUND, KIND_INT_LKUP: begin
			for (int i = map_count - 1; i >= 0; i--) begin
				if (idx < 0 && map_tbl[i].proto == rq.proto && map_tbl[i].ip == rq.inside_ip
						&& map_tbl[i].inside_port == rq.inside_port)
					idx = i;
			end
			if (idx >= 0) begin
				r.hit = 1'b1;
			end else if (rq.kind == KIND_OUTBOUND) begin
				if (map_count >= TABLE_DEPTH) begin
					r.table_full = 1'b1;
				end else begin
					map_tbl[map_count].proto = rq.proto;
					map_tbl[map_count].ip = rq.inside_ip;
					map_tbl[map_count].inside_port = rq.inside_port;
					map_tbl[map_count].outside_port = next_port[rq.proto];
					// hand out the counter value, then advance or wrap it
					bumped = {1'b0, next_port[rq.proto]} + 1'b1;
					next_port[rq.proto] = (bumped >= {1'b0, wrap_port}) ? lo_port
						: bumped[PORT_W-1:0];
					idx = map_count;
					map_count++;
					r.created = 1'b1;
				end
			end
		end
		KIND_EXT_LKUP: begin
			for (int i = map_count - 1; i >= 0; i--) begin
				if (idx < 0 && map_tbl[i].proto == rq.proto
						&& map_tbl[i].outside_port == rq.outside_port)
					idx = i;
			end
			if (idx >= 0)
				r.hit = 1'b1;
		end
		default: ;
		endcase
		if (idx >= 0) begin
			r.mapped_ip = map_tbl[idx].ip;
			r.mapped_inside_port = map_tbl[idx].inside_port;
			r.mapped_outside_port = map_tbl[idx].outside_port;
		end
		return r;
	endfunction

	// Build one random request, mostly aimed at known hosts and allocated ports
	function automatic req_t next_request(inout int fresh_left);
		req_t      rq;
		host_key_t hk;
		ent_t      ent;
		int        roll;
		int        sub;
		rq.kind = KIND_UNUSED;
		rq.proto = 1'($urandom_range(1));
		rq.inside_ip = $urandom;
		rq.inside_port = PORT_W'($urandom_range(65535));
		rq.outside_port = PORT_W'($urandom_range(65535));
		roll = $urandom_range(99);
		sub = $urandom_range(9);
		hk = hosts[$urandom_range(hosts.size() - 1)];
		if (roll < 45) begin
			rq.kind = KIND_OUTBOUND;
			if (fresh_left > 0 && sub < 5) begin
				hosts.push_back({rq.proto, rq.inside_ip, rq.inside_port});
				fresh_left--;
			end else begin
				{rq.proto, rq.inside_ip, rq.inside_port} = hk;
			end
		end else if (roll < 65) begin
			rq.kind = KIND_INT_LKUP;
			if (sub < 6) begin
				{rq.proto, rq.inside_ip, rq.inside_port} = hk;
			end else if (sub < 8) begin
				// near miss: same host, other protocol or neighboring port
				{rq.proto, rq.inside_ip, rq.inside_port} = hk;
				if (sub == 6)
					rq.proto = ~hk.proto;
				else
					rq.inside_port = hk.port ^ 16'h0001;
			end
		end else if (roll < 92) begin
			rq.kind = KIND_EXT_LKUP;
			if (sub < 5 && map_count > 0) begin
				ent = map_tbl[$urandom_range(map_count - 1)];
				rq.proto = ent.proto;
				rq.outside_port = ent.outside_port;
			end else if (sub < 8) begin
				rq.outside_port = lo_port + PORT_W'($urandom_range(15));
			end
		end
		return rq;
	endfunction

	task automatic report_mismatch(input string what, input logic [IP_W-1:0] got,
			input logic [IP_W-1:0] want);
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want,
			cycle_count);
		mismatch_count++;
	endtask

	task automatic check_word(input res_t got);
		res_t want;
		if (translations_due.size() == 0) begin
			report_mismatch("result with no request outstanding", got.mapped_ip, '0);
		end else begin
			want = translations_due.pop_front();
			if (got.hit !== want.hit)
				report_mismatch("hit", IP_W'(got.hit), IP_W'(want.hit));
			if (got.created !== want.created)
				report_mismatch("created", IP_W'(got.created), IP_W'(want.created));
			if (got.table_full !== want.table_full)
				report_mismatch("table_full", IP_W'(got.table_full),
					IP_W'(want.table_full));
			if (got.mapped_ip !== want.mapped_ip)
				report_mismatch("mapped_ip", got.mapped_ip, want.mapped_ip);
			if (got.mapped_inside_port !== want.mapped_inside_port)
				report_mismatch("mapped_inside_port", IP_W'(got.mapped_inside_port),
					IP_W'(want.mapped_inside_port));
			if (got.mapped_outside_port !== want.mapped_outside_port)
				report_mismatch("mapped_outside_port", IP_W'(got.mapped_outside_port),
					IP_W'(want.mapped_outside_port));
		end
	endtask

	// Driver: offer the oldest pending word, hold it while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				translations_due.push_back(napt_translate(in_word));
				void'(requests_pending.pop_front());
			end
			if (!(in_valid && in_stall)) begin
				if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_word <= requests_pending[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check accepted results, drive random or long stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_word(out_word);
			if (squeeze_left > 0) begin
				squeeze_left--;
				out_stall <= 1'b1;
			end else if (squeeze_armed && out_valid) begin
				squeeze_armed = 1'b0;
				squeeze_left = SQUEEZE_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct;
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic drain();
		while (requests_pending.size() != 0 || translations_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [PORT_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MIN_PORT) begin
			lo_port = val;
			next_port[0] = val;
			next_port[1] = val;
		end else begin
			wrap_port = val;
		end
	endtask

	task automatic offer(input logic [1:0] k, input logic p, input logic [IP_W-1:0] ip,
			input logic [PORT_W-1:0] host_port, input logic [PORT_W-1:0] outside);
		req_t rq;
		rq.kind = k;
		rq.proto = p;
		rq.inside_ip = ip;
		rq.inside_port = host_port;
		rq.outside_port = outside;
		requests_pending.push_back(rq);
		if (k == KIND_OUTBOUND)
			hosts.push_back({p, ip, host_port});
	endtask

	task automatic run_phase(input int fresh, input int s_pct, input int r_pct);
		int fresh_left;
		fresh_left = fresh;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (PHASE_WORDS)
			requests_pending.push_back(next_request(fresh_left));
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 26;
		recv_idle_pct = 66;

		// empty table, unused kind, field extremes, both protocols
		offer(KIND_INT_LKUP, 1'b0, 32'h0, 16'h0, 16'h0);
		offer(KIND_EXT_LKUP, 1'b1, 32'h0, 16'h0, 16'hFFFF);
		offer(KIND_UNUSED, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		offer(KIND_OUTBOUND, 1'b0, 32'h0, 16'h0, 16'hFFFF);
		offer(KIND_OUTBOUND, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
		offer(KIND_OUTBOUND, 1'b0, 32'h0, 16'h0, 16'h0);
		offer(KIND_OUTBOUND, 1'b1, 32'h0, 16'h0, 16'h0);
		offer(KIND_INT_LKUP, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
		offer(KIND_INT_LKUP, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
		offer(KIND_EXT_LKUP, 1'b0, 32'h0, 16'h0, MIN_PORT_RST);
		offer(KIND_EXT_LKUP, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, MIN_PORT_RST);
		offer(KIND_EXT_LKUP, 1'b1, 32'h0, 16'h0, MIN_PORT_RST + 16'd1);
		offer(KIND_EXT_LKUP, 1'b0, 32'h0, 16'h0, MIN_PORT_RST + 16'd1);
		offer(KIND_OUTBOUND, 1'b0, 32'h0A00_0001, 16'd80, 16'h0);
		offer(KIND_EXT_LKUP, 1'b0, 32'h0, 16'h0, MIN_PORT_RST + 16'd1);
		drain();

		// reload the counters so a port is handed out twice: newest entry wins
		write_reg(CFG_MIN_PORT, MIN_PORT_RST);
		offer(KIND_OUTBOUND, 1'b0, 32'hC0A8_0001, 16'h1234, 16'h0);
		offer(KIND_EXT_LKUP, 1'b0, 32'h0, 16'h0, MIN_PORT_RST);
		offer(KIND_UNUSED, 1'b0, 32'h0, 16'h0, 16'h0);
		offer(KIND_EXT_LKUP, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
		drain();

		// default range, sender light, receiver heavy
		run_phase(12, 26, 66);

		// top of the port space, wraps every two allocations
		write_reg(CFG_MIN_PORT, 16'd65533);
		write_reg(CFG_MAX_PORT, 16'hFFFF);
		run_phase(10, 26, 66);

		// lowest range: every allocation wraps to zero
		write_reg(CFG_MIN_PORT, 16'd0);
		write_reg(CFG_MAX_PORT, 16'd1);
		run_phase(6, 66, 26);

		// widen the range without reloading the counters; hold off the output once
		write_reg(CFG_MAX_PORT, 16'd5);
		squeeze_armed = 1'b1;
		run_phase(10, 66, 26);

		// single port at the very top
		write_reg(CFG_MIN_PORT, 16'hFFFF);
		write_reg(CFG_MAX_PORT, 16'hFFFF);
		run_phase(4, 0, 0);

		// wrap limit below the first port
		write_reg(CFG_MIN_PORT, 16'd5000);
		write_reg(CFG_MAX_PORT, 16'd100);
		run_phase(4, 0, 0);

		// fill the table and keep going while it is full
		write_reg(CFG_MIN_PORT, 16'd40000);
		write_reg(CFG_MAX_PORT, 16'hFFFF);
		run_phase(100, 0, 0);

		drain();
		repeat (80) @(posedge clk);
		if (translations_due.size() != 0)
			report_mismatch("results never arrived", translations_due.size(), '0);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
